@@ rtl/cs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character constants and helpers for the comment stripper.
// Depends on nothing; every other file of the block uses it.
package cs_pkg;

    localparam int CHAR_BITS = 16;

    typedef logic [CHAR_BITS-1:0] t_char;

    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_LINE  = 3'd1,
        MODE_BLOCK = 3'd2,
        MODE_STR   = 3'd3,
        MODE_RUNE  = 3'd4,
        MODE_RAW   = 3'd5
    } t_mode;

    localparam t_char CH_SLASH  = t_char'(8'h2F);
    localparam t_char CH_STAR   = t_char'(8'h2A);
    localparam t_char CH_TICK   = t_char'(8'h60);
    localparam t_char CH_BSLASH = t_char'(8'h5C);
    localparam t_char CH_NL     = t_char'(8'h0A);
    localparam t_char CH_DQUOTE = t_char'(8'h22);
    localparam t_char CH_SQUOTE = t_char'(8'h27);

    typedef struct packed {
        logic [1:0] cnt;
        t_char      c0;
        t_char      c1;
    } t_bundle;

    function automatic t_bundle emit(t_bundle b, t_char c);
        t_bundle r;
        r = b;
        if (b.cnt == 2'd0) begin
            r.c0 = c;
        end else begin
            r.c1 = c;
        end
        r.cnt = b.cnt + 2'd1;
        return r;
    endfunction

endpackage

@@ rtl/cs_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the comment stripper input and output.
// Depends on cs_pkg for the character type.
interface cs_in_if;
    logic           valid;
    logic           ready;
    cs_pkg::t_char  ch;
    logic           last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink (input valid, input ch, input last_char, output ready);
endinterface

interface cs_out_if;
    logic           valid;
    logic           ready;
    cs_pkg::t_char  out_ch;
    logic           last_of_run;

    modport source (output valid, output out_ch, output last_of_run, input ready);
    modport sink (input valid, input out_ch, input last_of_run, output ready);
endinterface

@@ rtl/cs_lexer.sv @@
`timescale 1ns / 1ps
// Lexer mode state and the per-character decision of which characters are kept.
// Depends on cs_pkg.
module cs_lexer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  cs_pkg::t_char   i_ch,
    input  logic            i_last,
    output cs_pkg::t_bundle o_bundle
);

    cs_pkg::t_mode r_mode, n_mode;
    logic          r_held, n_held;
    logic          r_star, n_star;
    logic          r_esc, n_esc;
    cs_pkg::t_bundle b;

    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        n_star = r_star;
        n_esc  = r_esc;
        b      = '0;
        case (r_mode)
            cs_pkg::MODE_LINE: begin
                if (i_ch == cs_pkg::CH_NL) begin
                    b      = cs_pkg::emit(b, i_ch);
                    n_mode = cs_pkg::MODE_CODE;
                end
            end
            cs_pkg::MODE_BLOCK: begin
                if (r_star && i_ch == cs_pkg::CH_SLASH) begin
                    n_star = 1'b0;
                    n_mode = cs_pkg::MODE_CODE;
                end else begin
                    n_star = (i_ch == cs_pkg::CH_STAR);
                    if (i_ch == cs_pkg::CH_NL) begin
                        b = cs_pkg::emit(b, i_ch);
                    end
                end
            end
            cs_pkg::MODE_STR, cs_pkg::MODE_RUNE: begin
                b = cs_pkg::emit(b, i_ch);
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_ch == cs_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if ((r_mode == cs_pkg::MODE_STR && i_ch == cs_pkg::CH_DQUOTE) ||
                             (r_mode == cs_pkg::MODE_RUNE && i_ch == cs_pkg::CH_SQUOTE)) begin
                    n_mode = cs_pkg::MODE_CODE;
                end
            end
            cs_pkg::MODE_RAW: begin
                b = cs_pkg::emit(b, i_ch);
                if (i_ch == cs_pkg::CH_TICK) begin
                    n_mode = cs_pkg::MODE_CODE;
                end
            end
            default: begin
                n_mode = cs_pkg::MODE_CODE;
                if (r_held && i_ch == cs_pkg::CH_SLASH) begin
                    n_held = 1'b0;
                    n_mode = cs_pkg::MODE_LINE;
                end else if (r_held && i_ch == cs_pkg::CH_STAR) begin
                    n_held = 1'b0;
                    n_mode = cs_pkg::MODE_BLOCK;
                    n_star = 1'b0;
                end else begin
                    if (r_held) begin
                        n_held = 1'b0;
                        b      = cs_pkg::emit(b, cs_pkg::CH_SLASH);
                    end
                    if (i_ch == cs_pkg::CH_SLASH) begin
                        n_held = 1'b1;
                    end else begin
                        if (i_ch == cs_pkg::CH_TICK) begin
                            n_mode = cs_pkg::MODE_RAW;
                        end else if (i_ch == cs_pkg::CH_DQUOTE) begin
                            n_mode = cs_pkg::MODE_STR;
                        end else if (i_ch == cs_pkg::CH_SQUOTE) begin
                            n_mode = cs_pkg::MODE_RUNE;
                        end
                        b = cs_pkg::emit(b, i_ch);
                    end
                end
            end
        endcase
        if (i_last) begin
            if (n_held) begin
                b = cs_pkg::emit(b, cs_pkg::CH_SLASH);
            end
            n_mode = cs_pkg::MODE_CODE;
            n_held = 1'b0;
            n_star = 1'b0;
            n_esc  = 1'b0;
        end
    end

    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cs_pkg::MODE_CODE;
            r_held <= 1'b0;
            r_star <= 1'b0;
            r_esc  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_star <= n_star;
            r_esc  <= n_esc;
        end
    end

endmodule

@@ rtl/cs_outbuf.sv @@
`timescale 1ns / 1ps
// Two-entry result register; one kept character out per cycle when ready.
// Depends on cs_pkg and the cs_out_if channel interface.
module cs_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  cs_pkg::t_bundle i_bundle,
    output logic            o_free,
    cs_out_if.source        o_out
);

    logic [1:0]    r_cnt, n_cnt;
    cs_pkg::t_char r_c0, n_c0;
    cs_pkg::t_char r_c1, n_c1;
    logic          pop;

    assign pop    = (r_cnt != 2'd0) && o_out.ready;
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    always_comb begin
        n_cnt = r_cnt;
        n_c0  = r_c0;
        n_c1  = r_c1;
        if (pop) begin
            if (r_cnt == 2'd2) begin
                n_c0  = r_c1;
                n_cnt = 2'd1;
            end else begin
                n_cnt = 2'd0;
            end
        end
        if (i_load && o_free) begin
            n_cnt = i_bundle.cnt;
            n_c0  = i_bundle.c0;
            n_c1  = i_bundle.c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0 <= n_c0;
        r_c1 <= n_c1;
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.out_ch      = r_c0;
    assign o_out.last_of_run = (r_cnt == 2'd1);

endmodule

@@ rtl/comment_stripper.sv @@
`timescale 1ns / 1ps
// Top level of the comment stripper: input register, lexer and result buffer.
// Depends on cs_pkg, cs_ifs, cs_lexer and cs_outbuf.
//
// Source text enters on i_in one character per request, with last_char set
// on the final character of a text. Kept characters leave on o_out, one per
// request; last_of_run marks the final character caused by one input.
// Comments are removed except for their newlines; strings, runes and raw
// strings pass unchanged. An input causes zero, one or two results.
// An accepted character is held in the input register and decoded into the
// two-entry result register once that has room; its first result is then
// offered on o_out. One character is accepted every cycle as long as the
// receiver is ready and each causes at most one result; a character that
// causes two results holds back the next one until its first result has left
// through the single output port.
// When the receiver stalls, the result register and the input register
// fill and i_in.ready drops; nothing is lost. Synchronous reset empties both
// registers and returns the lexer to plain code mode.
module comment_stripper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cs_in_if.sink     i_in,
    cs_out_if.source  o_out
);

    logic            r_a_valid;
    cs_pkg::t_char   r_a_ch;
    logic            r_a_last;
    logic            buf_free;
    logic            a_adv;
    cs_pkg::t_bundle bundle;

    assign a_adv      = r_a_valid && buf_free;
    assign i_in.ready = !r_a_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_ch   <= i_in.ch;
            r_a_last <= i_in.last_char;
        end
    end

    cs_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (a_adv),
        .i_ch     (r_a_ch),
        .i_last   (r_a_last),
        .o_bundle (bundle)
    );

    cs_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (a_adv),
        .i_bundle (bundle),
        .o_free   (buf_free),
        .o_out    (o_out)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for comment_stripper: a short scripted text, then random source text.
// Depends on cs_pkg, cs_ifs and the comment_stripper RTL.
module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 670;

    localparam cs_pkg::t_char CH_A  = 16'h0061;
    localparam cs_pkg::t_char CH_X  = 16'h0078;
    localparam cs_pkg::t_char CH_SP = 16'h0020;

    localparam cs_pkg::t_char SPECIALS [7] = '{cs_pkg::CH_SLASH, cs_pkg::CH_STAR,
                                               cs_pkg::CH_TICK, cs_pkg::CH_BSLASH,
                                               cs_pkg::CH_NL, cs_pkg::CH_DQUOTE,
                                               cs_pkg::CH_SQUOTE};

    typedef struct packed {
        cs_pkg::t_char ch;
        logic          last;
        logic          typed;
        logic [1:0]    n_res;
        cs_pkg::t_char r0;
        cs_pkg::t_char r1;
    } t_script_row;

    localparam t_script_row SCRIPT [25] = '{
        '{CH_A,              1'b0, 1'b1, 2'd1, CH_A,              16'h0},
        '{16'hFFFF,          1'b0, 1'b1, 2'd1, 16'hFFFF,          16'h0},
        '{16'h0000,          1'b0, 1'b1, 2'd1, 16'h0000,          16'h0},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b1, 2'd0, 16'h0,             16'h0},
        '{CH_X,              1'b0, 1'b1, 2'd2, cs_pkg::CH_SLASH,  CH_X},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b1, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b1, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_NL,     1'b0, 1'b1, 2'd1, cs_pkg::CH_NL,     16'h0},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b1, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_STAR,   1'b0, 1'b1, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_NL,     1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_DQUOTE, 1'b0, 1'b1, 2'd1, cs_pkg::CH_DQUOTE, 16'h0},
        '{cs_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_SQUOTE, 1'b0, 1'b1, 2'd1, cs_pkg::CH_SQUOTE, 16'h0},
        '{cs_pkg::CH_BSLASH, 1'b1, 1'b1, 2'd1, cs_pkg::CH_BSLASH, 16'h0},
        '{cs_pkg::CH_TICK,   1'b0, 1'b1, 2'd1, cs_pkg::CH_TICK,   16'h0},
        '{cs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_TICK,   1'b0, 1'b0, 2'd0, 16'h0,             16'h0},
        '{cs_pkg::CH_SLASH,  1'b1, 1'b1, 2'd1, cs_pkg::CH_SLASH,  16'h0}
    };

    typedef struct {
        cs_pkg::t_char ch;
        logic          last;
    } t_kept;

    logic clk;
    logic rst_n;

    cs_in_if  chars_in ();
    cs_out_if chars_out ();

    comment_stripper DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (chars_in),
        .o_out   (chars_out)
    );

    t_kept         kept_due [$];
    cs_pkg::t_char text_buf [$];

    cs_pkg::t_mode lex_state;
    bit            slash_held;
    bit            star_prev;
    bit            escape_next;

    int errors;
    int items_sent;
    int texts_sent;
    int results_checked;
    int comments_opened;
    int src_idle;
    int snk_idle;
    bit hold_req;
    int hold_left;
    int stalled;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic queue_kept(input cs_pkg::t_char c, input logic last);
        t_kept k;
        k.ch = c;
        k.last = last;
        kept_due.insert(kept_due.size(), k);
    endtask

    task automatic add_char(input cs_pkg::t_char c);
        text_buf.insert(text_buf.size(), c);
    endtask

    task automatic strip_predict(input cs_pkg::t_char c, input logic last, input bit record);
        cs_pkg::t_char kept [2];
        int            n;
        bit            as_code;
        n = 0;
        as_code = 1'b0;
        case (lex_state)
            cs_pkg::MODE_LINE: begin
                if (c == cs_pkg::CH_NL) begin
                    kept[n] = c;
                    n++;
                    lex_state = cs_pkg::MODE_CODE;
                end
            end
            cs_pkg::MODE_BLOCK: begin
                if (star_prev && c == cs_pkg::CH_SLASH) begin
                    star_prev = 1'b0;
                    lex_state = cs_pkg::MODE_CODE;
                end else begin
                    star_prev = (c == cs_pkg::CH_STAR);
                    if (c == cs_pkg::CH_NL) begin
                        kept[n] = c;
                        n++;
                    end
                end
            end
            cs_pkg::MODE_STR, cs_pkg::MODE_RUNE: begin
                kept[n] = c;
                n++;
                if (escape_next) begin
                    escape_next = 1'b0;
                end else if (c == cs_pkg::CH_BSLASH) begin
                    escape_next = 1'b1;
                end else if ((lex_state == cs_pkg::MODE_STR && c == cs_pkg::CH_DQUOTE) ||
                             (lex_state == cs_pkg::MODE_RUNE && c == cs_pkg::CH_SQUOTE)) begin
                    lex_state = cs_pkg::MODE_CODE;
                end
            end
            cs_pkg::MODE_RAW: begin
                kept[n] = c;
                n++;
                if (c == cs_pkg::CH_TICK) begin
                    lex_state = cs_pkg::MODE_CODE;
                end
            end
            default: begin
                lex_state = cs_pkg::MODE_CODE;
                as_code = 1'b1;
                if (slash_held) begin
                    slash_held = 1'b0;
                    if (c == cs_pkg::CH_SLASH) begin
                        lex_state = cs_pkg::MODE_LINE;
                        as_code = 1'b0;
                        comments_opened++;
                    end else if (c == cs_pkg::CH_STAR) begin
                        lex_state = cs_pkg::MODE_BLOCK;
                        star_prev = 1'b0;
                        as_code = 1'b0;
                        comments_opened++;
                    end else begin
                        kept[n] = cs_pkg::CH_SLASH;
                        n++;
                    end
                end
            end
        endcase
        if (as_code) begin
            if (c == cs_pkg::CH_SLASH) begin
                slash_held = 1'b1;
            end else begin
                if (c == cs_pkg::CH_TICK) begin
                    lex_state = cs_pkg::MODE_RAW;
                end else if (c == cs_pkg::CH_DQUOTE) begin
                    lex_state = cs_pkg::MODE_STR;
                end else if (c == cs_pkg::CH_SQUOTE) begin
                    lex_state = cs_pkg::MODE_RUNE;
                end
                kept[n] = c;
                n++;
            end
        end
        if (last) begin
            if (slash_held) begin
                kept[n] = cs_pkg::CH_SLASH;
                n++;
            end
            lex_state = cs_pkg::MODE_CODE;
            slash_held = 1'b0;
            star_prev = 1'b0;
            escape_next = 1'b0;
        end
        if (record) begin
            for (int i = 0; i < n; i++) begin
                queue_kept(kept[i], i == n - 1);
            end
        end
    endtask

    task automatic send_char(input cs_pkg::t_char c, input logic last, input bit typed = 1'b0,
                             input int n_res = 0, input cs_pkg::t_char r0 = '0,
                             input cs_pkg::t_char r1 = '0);
        while ($urandom_range(99) < src_idle) begin
            chars_in.valid <= 1'b0;
            @(posedge clk);
        end
        chars_in.valid     <= 1'b1;
        chars_in.ch        <= c;
        chars_in.last_char <= last;
        @(posedge clk);
        while (!chars_in.ready) begin
            @(posedge clk);
        end
        items_sent++;
        strip_predict(c, last, !typed);
        if (typed) begin
            if (n_res > 0) begin
                queue_kept(r0, n_res == 1);
            end
            if (n_res > 1) begin
                queue_kept(r1, 1'b1);
            end
        end
    endtask

    task automatic drain_results();
        chars_in.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (kept_due.size() != 0);
    endtask

    function automatic cs_pkg::t_char pick_char();
        case ($urandom_range(9))
            0, 1, 2: return SPECIALS[$urandom_range(6)];
            3, 4, 5, 6: return CH_A + cs_pkg::t_char'($urandom_range(25));
            7: return ($urandom_range(1) != 0) ? cs_pkg::CH_NL : CH_SP;
            default: return cs_pkg::t_char'($urandom_range(65535));
        endcase
    endfunction

    task automatic append_token();
        int kind;
        int len;
        bit broken;
        kind = $urandom_range(99);
        len = $urandom_range(6);
        broken = ($urandom_range(19) == 0);
        if (kind < 25) begin
            repeat (len + 1) add_char(CH_A + cs_pkg::t_char'($urandom_range(25)));
        end else if (kind < 35) begin
            add_char(cs_pkg::CH_DQUOTE);
            repeat (len) begin
                if ($urandom_range(4) == 0) begin
                    add_char(cs_pkg::CH_BSLASH);
                end
                add_char(pick_char());
            end
            if (!broken) add_char(cs_pkg::CH_DQUOTE);
        end else if (kind < 42) begin
            add_char(cs_pkg::CH_SQUOTE);
            if ($urandom_range(2) == 0) begin
                add_char(cs_pkg::CH_BSLASH);
            end
            add_char(pick_char());
            if (!broken) add_char(cs_pkg::CH_SQUOTE);
        end else if (kind < 50) begin
            add_char(cs_pkg::CH_TICK);
            repeat (len) add_char(pick_char());
            if (!broken) add_char(cs_pkg::CH_TICK);
        end else if (kind < 62) begin
            add_char(cs_pkg::CH_SLASH);
            add_char(cs_pkg::CH_SLASH);
            repeat (len) add_char(pick_char());
            if (!broken) add_char(cs_pkg::CH_NL);
        end else if (kind < 74) begin
            add_char(cs_pkg::CH_SLASH);
            add_char(cs_pkg::CH_STAR);
            repeat (len) add_char(pick_char());
            if (!broken) begin
                add_char(cs_pkg::CH_STAR);
                add_char(cs_pkg::CH_SLASH);
            end
        end else if (kind < 82) begin
            add_char(cs_pkg::CH_SLASH);
            if (!broken) add_char(CH_SP);
        end else if (kind < 90) begin
            add_char(($urandom_range(1) != 0) ? cs_pkg::CH_NL : CH_SP);
        end else begin
            repeat (len + 1) add_char(cs_pkg::t_char'($urandom_range(65535)));
        end
    endtask

    task automatic send_text();
        text_buf.delete();
        repeat ($urandom_range(1, 12)) append_token();
        foreach (text_buf[i]) begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
        texts_sent++;
    endtask

    always @(posedge clk) begin : check_output
        t_kept want;
        if (rst_n && chars_out.valid && chars_out.ready) begin
            if (kept_due.size() == 0) begin
                report_mismatch("unexpected character", 32'(chars_out.out_ch), '0);
            end else begin
                want = kept_due.pop_front();
                if (chars_out.out_ch !== want.ch) begin
                    report_mismatch("out_ch", 32'(chars_out.out_ch), 32'(want.ch));
                end
                if (chars_out.last_of_run !== want.last) begin
                    report_mismatch("last_of_run", 32'(chars_out.last_of_run),
                                    32'(want.last));
                end
                results_checked++;
            end
        end
    end

    initial begin
        chars_out.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                chars_out.ready <= 1'b0;
            end else begin
                chars_out.ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    initial begin
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((chars_in.valid && chars_in.ready) || (chars_out.valid && chars_out.ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("Watchdog expired after %0d cycles without a request.", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int  base;
        bit  held_once;
        bit  drained_once;
        errors = 0;
        items_sent = 0;
        texts_sent = 0;
        results_checked = 0;
        comments_opened = 0;
        hold_req = 1'b0;
        held_once = 1'b0;
        drained_once = 1'b0;
        src_idle = 34;
        snk_idle = 45;
        lex_state = cs_pkg::MODE_CODE;
        slash_held = 1'b0;
        star_prev = 1'b0;
        escape_next = 1'b0;
        rst_n <= 1'b0;
        chars_in.valid <= 1'b0;
        chars_in.ch <= '0;
        chars_in.last_char <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i]) begin
            send_char(SCRIPT[i].ch, SCRIPT[i].last, SCRIPT[i].typed, int'(SCRIPT[i].n_res),
                      SCRIPT[i].r0, SCRIPT[i].r1);
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle = (phase == 0) ? 34 : (phase == 1) ? 45 : 0;
            snk_idle = (phase == 0) ? 45 : (phase == 1) ? 34 : 0;
            base = items_sent;
            while (items_sent - base < PHASE_ITEMS) begin
                if (phase == 0 && !held_once && items_sent - base >= 200) begin
                    hold_req = 1'b1;
                    held_once = 1'b1;
                end
                if (phase == 1 && !drained_once && items_sent - base >= 300) begin
                    drain_results();
                    drained_once = 1'b1;
                end
                send_text();
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        $display("Sent %0d characters in %0d texts with %0d comments opened;",
                 items_sent, texts_sent, comments_opened);
        $display("checked %0d kept characters, %0d mismatches.", results_checked, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
